[rtl/urc_pkg.sv]
package urc_pkg;

  localparam int URC_COUNT_BITS = 20;

  localparam int TRIG_W     = 10;
  localparam int TIMEOUT_W  = 20;
  localparam int PAUSE_W    = 20;
  localparam int THR_W      = 18;
  localparam int DIST_W     = 18;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 2;

  localparam logic [TRIG_W-1:0]    TRIG_RESET    = 10'd11;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd1000000;
  localparam logic [PAUSE_W-1:0]   PAUSE_RESET   = 20'd500000;
  localparam logic [THR_W-1:0]     THR_RESET     = 18'd150;

  localparam int QUEUE_DEPTH = 4;

  // distance = floor(h * 17 / 50), h = width / 2
  localparam int                   H_W         = 20;
  localparam logic [H_W-1:0]       H_SAT       = 20'd771009;
  localparam int                   P_W         = 24;
  localparam int                   RECIP_W     = 25;
  localparam logic [RECIP_W-1:0]   RECIP       = 25'd21474837;
  localparam int                   RECIP_SHIFT = 30;
  localparam int                   MUL_W       = P_W + RECIP_W;
  localparam logic [DIST_W-1:0]    DIST_MAX    = 18'h3FFFF;

  typedef enum logic [1:0] {
    PH_TRIGGER,
    PH_LISTEN,
    PH_PAUSE
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE,
    EV_DIST,
    EV_TIMEOUT
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRIGGER_TICKS  = 2'd0,
    CFG_LISTEN_TIMEOUT = 2'd1,
    CFG_PAUSE_TICKS    = 2'd2,
    CFG_NEAR_THRESHOLD = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic           trig;
    event_t         ev;
    logic           sat;
    logic [H_W-1:0] half_width;
  } job_t;

endpackage

[rtl/urc_ifs.sv]
interface urc_in_if ();
  logic valid;
  logic ready;
  logic echo_level;

  modport source (output valid, output echo_level, input ready);
  modport sink (input valid, input echo_level, output ready);
endinterface

interface urc_out_if import urc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              trigger_level;
  logic              led_level;
  logic              distance_valid;
  logic [DIST_W-1:0] distance_mm;
  logic              timed_out;

  modport source (output valid, output trigger_level, output led_level,
                  output distance_valid, output distance_mm, output timed_out,
                  input ready);
  modport sink (input valid, input trigger_level, input led_level,
                input distance_valid, input distance_mm, input timed_out,
                output ready);
endinterface

[rtl/urc_front.sv]
module urc_front import urc_pkg::*; #(
  parameter int COUNT_BITS = URC_COUNT_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 echo,
  input  logic [TRIG_W-1:0]    trigger_ticks,
  input  logic [TIMEOUT_W-1:0] listen_timeout,
  input  logic [PAUSE_W-1:0]   pause_ticks,
  input  logic                 q_full,
  output logic                 push,
  output job_t                 push_job
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  phase_t                phase_r, phase_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [COUNT_BITS-1:0] wid_r, wid_nxt;
  logic                  rise_seen_r, rise_seen_nxt;
  logic                  echo_prev_r;

  logic                  acc;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [COUNT_BITS-1:0] wid_inc;
  logic [31:0]           limit;
  logic                  reach;
  logic                  rise;
  logic                  fall;
  logic [31:0]           half32;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign push     = acc;

  assign cnt_inc = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;
  assign wid_inc = (wid_r == CNT_MAX) ? wid_r : wid_r + 1'b1;
  assign rise    = echo && !echo_prev_r;
  assign fall    = !echo && echo_prev_r && rise_seen_r;
  assign reach   = 32'(cnt_inc) >= limit;
  assign half32  = 32'(wid_r[COUNT_BITS-1:1]);

  always_comb begin
    unique case (phase_r)
      PH_TRIGGER: limit = 32'(trigger_ticks);
      PH_LISTEN:  limit = 32'(listen_timeout);
      PH_PAUSE:   limit = 32'(pause_ticks);
      default:    limit = '0;
    endcase
  end

  // next state
  always_comb begin
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_inc;
    wid_nxt       = wid_r;
    rise_seen_nxt = rise_seen_r;
    unique case (phase_r)
      PH_TRIGGER: begin
        if (reach) begin
          phase_nxt     = PH_LISTEN;
          cnt_nxt       = '0;
          wid_nxt       = '0;
          rise_seen_nxt = 1'b0;
        end
      end
      PH_LISTEN: begin
        if (rise) begin
          rise_seen_nxt = 1'b1;
          wid_nxt       = COUNT_BITS'(1);
        end else if (echo && rise_seen_r) begin
          wid_nxt = wid_inc;
        end
        if (fall || reach) begin
          phase_nxt = PH_PAUSE;
          cnt_nxt   = '0;
        end
      end
      PH_PAUSE: begin
        if (reach) begin
          phase_nxt = PH_TRIGGER;
          cnt_nxt   = '0;
        end
      end
      default: begin
        phase_nxt = PH_TRIGGER;
        cnt_nxt   = '0;
      end
    endcase
  end

  // outputs
  always_comb begin
    push_job.trig       = (phase_r == PH_TRIGGER);
    push_job.ev         = EV_NONE;
    push_job.sat        = half32 >= 32'(H_SAT);
    push_job.half_width = half32[H_W-1:0];
    if (phase_r == PH_LISTEN) begin
      if (fall) begin
        push_job.ev = EV_DIST;
      end else if (reach) begin
        push_job.ev = EV_TIMEOUT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TRIGGER;
      cnt_r       <= '0;
      wid_r       <= '0;
      rise_seen_r <= 1'b0;
      echo_prev_r <= 1'b0;
    end else if (acc) begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      wid_r       <= wid_nxt;
      rise_seen_r <= rise_seen_nxt;
      echo_prev_r <= echo;
    end
  end

endmodule

[rtl/urc_queue.sv]
module urc_queue import urc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t pop_job,
  output logic full,
  output logic empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign pop_job = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

[rtl/urc_back.sv]
module urc_back import urc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  job_t              q_job,
  output logic              q_pop,
  input  logic [THR_W-1:0]  near_threshold,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              trigger_level,
  output logic              led_level,
  output logic              distance_valid,
  output logic [DIST_W-1:0] distance_mm,
  output logic              timed_out
);

  logic              adv;
  logic [P_W-1:0]    p17;
  logic [MUL_W-1:0]  prod;
  logic [DIST_W-1:0] dist_c;
  logic              led_c;

  logic              s1_v_r;
  job_t              s1_job_r;
  logic [P_W-1:0]    s1_p_r;

  logic              s2_v_r;
  logic              s2_trig_r;
  event_t            s2_ev_r;
  logic              s2_sat_r;
  logic [DIST_W-1:0] s2_q_r;

  logic              s3_v_r;
  logic              led_r;
  logic              trig_o_r;
  logic              dvalid_o_r;
  logic [DIST_W-1:0] dist_o_r;
  logic              tmo_o_r;

  assign adv   = !s3_v_r || out_ready;
  assign q_pop = adv && !q_empty;

  assign p17  = P_W'({q_job.half_width, 4'b0000}) + P_W'(q_job.half_width);
  assign prod = MUL_W'(s1_p_r) * MUL_W'(RECIP);

  always_comb begin
    dist_c = '0;
    led_c  = led_r;
    if (s2_ev_r == EV_DIST) begin
      dist_c = s2_sat_r ? DIST_MAX : s2_q_r;
      led_c  = (dist_c < near_threshold);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_job_r   <= q_job;
      s1_p_r     <= p17;
      s2_trig_r  <= s1_job_r.trig;
      s2_ev_r    <= s1_job_r.ev;
      s2_sat_r   <= s1_job_r.sat;
      s2_q_r     <= prod[RECIP_SHIFT +: DIST_W];
      trig_o_r   <= s2_trig_r;
      dvalid_o_r <= (s2_ev_r == EV_DIST);
      dist_o_r   <= dist_c;
      tmo_o_r    <= (s2_ev_r == EV_TIMEOUT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      led_r  <= 1'b0;
    end else if (adv) begin
      s1_v_r <= q_pop;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      if (s2_v_r) begin
        led_r <= led_c;
      end
    end
  end

  assign out_valid      = s3_v_r;
  assign trigger_level  = trig_o_r;
  assign led_level      = led_r;
  assign distance_valid = dvalid_o_r;
  assign distance_mm    = dist_o_r;
  assign timed_out      = tmo_o_r;

endmodule

[rtl/ultrasonic_range_controller.sv]
// Channel   Dir  Handshake      Payload
// in_ch     in   valid/ready    echo_level
// out_ch    out  valid/ready    trigger_level, led_level, distance_valid,
//                               distance_mm, timed_out
// cfg       in   cfg_we         cfg_index, cfg_wdata
//
// One item per cycle while the queue is not full; one result per item, via queue, s1, s2, s3.
// Front phase counter and echo timer advance once per accepted item.
// Back end: x17, reciprocal multiply, then clamp and LED compare, one stage each.
// Output stall freezes the back end; the front keeps taking items until the
// 4-entry queue is full. Reset is synchronous; no clearing pass.
module ultrasonic_range_controller import urc_pkg::*; #(
  parameter int COUNT_BITS = URC_COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  urc_in_if.sink                in_ch,
  urc_out_if.source             out_ch
);

  logic [TRIG_W-1:0]    trigger_ticks_r;
  logic [TIMEOUT_W-1:0] listen_timeout_r;
  logic [PAUSE_W-1:0]   pause_ticks_r;
  logic [THR_W-1:0]     near_threshold_r;

  logic push;
  job_t push_job;
  logic q_pop;
  job_t q_job;
  logic q_full;
  logic q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trigger_ticks_r  <= TRIG_RESET;
      listen_timeout_r <= TIMEOUT_RESET;
      pause_ticks_r    <= PAUSE_RESET;
      near_threshold_r <= THR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TRIGGER_TICKS:  trigger_ticks_r  <= cfg_wdata[TRIG_W-1:0];
        CFG_LISTEN_TIMEOUT: listen_timeout_r <= cfg_wdata[TIMEOUT_W-1:0];
        CFG_PAUSE_TICKS:    pause_ticks_r    <= cfg_wdata[PAUSE_W-1:0];
        CFG_NEAR_THRESHOLD: near_threshold_r <= cfg_wdata[THR_W-1:0];
      endcase
    end
  end

  urc_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .echo           (in_ch.echo_level),
    .trigger_ticks  (trigger_ticks_r),
    .listen_timeout (listen_timeout_r),
    .pause_ticks    (pause_ticks_r),
    .q_full         (q_full),
    .push           (push),
    .push_job       (push_job)
  );

  urc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (q_pop),
    .pop_job  (q_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  urc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_job          (q_job),
    .q_pop          (q_pop),
    .near_threshold (near_threshold_r),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .trigger_level  (out_ch.trigger_level),
    .led_level      (out_ch.led_level),
    .distance_valid (out_ch.distance_valid),
    .distance_mm    (out_ch.distance_mm),
    .timed_out      (out_ch.timed_out)
  );

endmodule
